>>> rtl/length_prefixed_deframer_defines.svh
// Assertion macros for the length-prefixed deframer.
`ifndef LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define LPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");
`else
`define LPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/lpd_pkg.sv
// Constants and types for the length-prefixed deframer.
package lpd_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int HDR_CNT_W    = 3;
   localparam int LEN_W        = 32;
   localparam int MAX_LEN_W    = 31;

   localparam logic [LEN_W-1:0]     HEADER_LEN    = LEN_W'(HEADER_BYTES);
   localparam logic [HDR_CNT_W:0]   HEADER_CNT    = (HDR_CNT_W + 1)'(HEADER_BYTES);
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(128 * 1024);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_DROPPED = 2'd2
   } frame_status_type;

endpackage

>>> rtl/length_prefixed_deframer.sv
// Length-prefixed deframer: splits a byte stream into messages, one result per byte.
// Takes one byte per clock and registers each result in a single output
// register; a new byte is taken whenever that register is empty or is being emptied in
// the same cycle, so throughput is one byte per cycle while rsp_ready stays high. Each
// message opens with a 4-byte little-endian length that counts the header; a length
// below 4 or above csr_max_message_len raises a sticky error, after which every byte is
// returned as dropped until reset. The limit may be changed only while the block is idle.
`include "length_prefixed_deframer_defines.svh"

module length_prefixed_deframer
   import lpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_first_of_message,
   output logic                 rsp_last_of_message,
   output logic [1:0]           rsp_frame_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [MAX_LEN_W-1:0] csr_max_message_len
);

   logic [MAX_LEN_W-1:0] max_len_ff, max_len_in;
   logic [HDR_CNT_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [LEN_W-1:0]     len_word_ff, len_word_in;
   logic [MAX_LEN_W-1:0] remaining_ff, remaining_in;
   logic                 error_ff, error_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 first_ff, first_in;
   logic                 last_ff, last_in;
   frame_status_type     status_ff, status_in;

   logic                 accept;
   logic [LEN_W-1:0]     len_base;
   logic [LEN_W-1:0]     len_new;
   logic [MAX_LEN_W-1:0] rem_dec;
   logic [LEN_W-1:0]     body_len;
   logic                 hdr_done;
   logic                 len_bad;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = !reset;

   assign len_base = (hdr_cnt_ff == '0) ? '0 : len_word_ff;
   assign rem_dec  = remaining_ff - MAX_LEN_W'(1);
   assign hdr_done = ({1'b0, hdr_cnt_ff} + (HDR_CNT_W + 1)'(1)) >= HEADER_CNT;
   assign body_len = len_new - HEADER_LEN;
   assign len_bad  = (len_new < HEADER_LEN) || (len_new > {1'b0, max_len_ff});

   always_comb begin
      if (hdr_cnt_ff < HDR_CNT_W'(4)) begin
         len_new = len_base | ({24'd0, req_in_byte} << {hdr_cnt_ff[1:0], 3'b000});
      end else if (req_in_byte != 8'd0) begin
         len_new = '1;
      end else begin
         len_new = len_base;
      end
   end

   always_comb begin
      max_len_in   = max_len_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      len_word_in  = len_word_ff;
      remaining_in = remaining_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      if (csr_valid && csr_ready) begin
         max_len_in = csr_max_message_len;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = req_in_byte;
         first_in     = 1'b0;
         last_in      = 1'b0;
         status_in    = STATUS_OK;
         if (error_ff) begin
            out_byte_in = 8'd0;
            status_in   = STATUS_DROPPED;
         end else if (remaining_ff != '0) begin
            remaining_in = rem_dec;
            if (rem_dec == '0) begin
               last_in     = 1'b1;
               len_word_in = '0;
            end
         end else begin
            first_in    = (hdr_cnt_ff == '0);
            len_word_in = len_new;
            if (!hdr_done) begin
               hdr_cnt_in = hdr_cnt_ff + HDR_CNT_W'(1);
            end else begin
               hdr_cnt_in = '0;
               if (len_bad) begin
                  error_in    = 1'b1;
                  status_in   = STATUS_BAD_LEN;
                  len_word_in = '0;
               end else begin
                  remaining_in = body_len[MAX_LEN_W-1:0];
                  if (body_len[MAX_LEN_W-1:0] == '0) begin
                     last_in     = 1'b1;
                     len_word_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         hdr_cnt_ff   <= '0;
         len_word_ff  <= '0;
         remaining_ff <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         len_word_ff  <= len_word_in;
         remaining_ff <= remaining_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = out_byte_ff;
   assign rsp_first_of_message = first_ff;
   assign rsp_last_of_message  = last_ff;
   assign rsp_frame_status     = status_ff;

   // sticky error: every later transaction is dropped
   `LPD_ASSERT_NEXT(a_drop_sticky, clock, reset, accept && error_ff, status_ff == STATUS_DROPPED)
   `LPD_ASSERT_SAME(a_last_is_ok, clock, reset, rsp_valid && last_ff, status_ff == STATUS_OK)
   `LPD_ASSERT_SAME(a_bad_len_latched, clock, reset, rsp_valid && status_ff == STATUS_BAD_LEN, error_ff)
   `LPD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte_ff))

endmodule

>>> test/length_prefixed_deframer_tb.sv
// Self-checking testbench for length_prefixed_deframer: random framed byte streams.
module length_prefixed_deframer_tb
   import lpd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]       data;
      logic             sof;
      logic             eof;
      frame_status_type status;
   } beat_type;

   class deframe_scoreboard_type;
      logic [HDR_CNT_W-1:0] hdr_pos;
      logic [LEN_W-1:0]     len_acc;
      logic [MAX_LEN_W-1:0] body_left;
      bit                   err_sticky;
      logic [MAX_LEN_W-1:0] max_len;
      beat_type             expected_beats[$];
      int                   failures;

      function new();
         hdr_pos    = '0;
         len_acc    = '0;
         body_left  = '0;
         err_sticky = 1'b0;
         max_len    = MAX_LEN_RESET;
         failures   = 0;
      endfunction

      function void set_max(logic [MAX_LEN_W-1:0] v);
         max_len = v;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // accepted input transaction: advance the framing state, queue the expected beat
      function void note_byte(logic [7:0] b);
         beat_type e;
         e = '{data: b, sof: 1'b0, eof: 1'b0, status: STATUS_OK};
         if (err_sticky) begin
            e.data   = 8'h00;
            e.status = STATUS_DROPPED;
         end else if (body_left != 0) begin
            body_left = body_left - 1'b1;
            if (body_left == 0) begin
               e.eof   = 1'b1;
               len_acc = '0;
            end
         end else begin
            e.sof = (hdr_pos == 0);
            if (hdr_pos == 0) len_acc = '0;
            if (hdr_pos < 4) len_acc = len_acc | (LEN_W'(b) << (8 * hdr_pos));
            else if (b != 0) len_acc = '1;
            if (int'(hdr_pos) + 1 < HEADER_BYTES) begin
               hdr_pos = hdr_pos + 1'b1;
            end else begin
               hdr_pos = '0;
               if (len_acc < HEADER_LEN || len_acc > LEN_W'(max_len)) begin
                  err_sticky = 1'b1;
                  e.status   = STATUS_BAD_LEN;
                  len_acc    = '0;
               end else begin
                  body_left = MAX_LEN_W'(len_acc - HEADER_LEN);
                  if (body_left == 0) begin
                     e.eof   = 1'b1;
                     len_acc = '0;
                  end
               end
            end
         end
         expected_beats.push_back(e);
      endfunction

      function void report(string field, int want, int got);
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_beat(beat_type got);
         beat_type want;
         if (expected_beats.size() == 0) begin
            failures++;
            $display("%0t: unexpected rsp transaction, expected none, actual byte %0d",
                     $time, got.data, " sof %0d eof %0d status %0d",
                     got.sof, got.eof, got.status);
            return;
         end
         want = expected_beats.pop_front();
         if (want.data !== got.data) report("out_byte", want.data, got.data);
         if (want.sof !== got.sof) report("first_of_message", want.sof, got.sof);
         if (want.eof !== got.eof) report("last_of_message", want.eof, got.eof);
         if (want.status !== got.status) report("frame_status", want.status, got.status);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_in_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_first_of_message;
   logic                 rsp_last_of_message;
   logic [1:0]           rsp_frame_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [MAX_LEN_W-1:0] csr_max_message_len;

   deframe_scoreboard_type sb;
   longint unsigned        cur_max;
   int                     send_run;
   bit                     send_quiet;
   int                     recv_run;
   bit                     recv_quiet;

   length_prefixed_deframer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_first_of_message (rsp_first_of_message),
      .rsp_last_of_message  (rsp_last_of_message),
      .rsp_frame_status     (rsp_frame_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_message_len  (csr_max_message_len)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("length_prefixed_deframer regression: fail");
      $finish;
   end

   // idle cycles before a transaction, with runs of back-to-back traffic
   function automatic int draw_gap(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         quiet    = ($urandom_range(0, 2) == 0);
         run_left = $urandom_range(5, 40);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap(send_run, send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic send_header(input logic [LEN_W-1:0] len);
      for (int i = 0; i < HEADER_BYTES; i++)
         send_byte(len[8*i +: 8]);
   endtask

   task automatic send_message(input longint unsigned len);
      send_header(LEN_W'(len));
      for (longint unsigned i = HEADER_BYTES; i < len; i++)
         send_byte(8'($urandom));
   endtask

   function automatic longint unsigned pick_msg_len();
      longint unsigned top;
      longint unsigned roomy;
      int              r;
      top   = (cur_max < 24) ? cur_max : 24;
      roomy = (cur_max < 300) ? cur_max : 300;
      r     = $urandom_range(0, 9);
      if (r == 0) return HEADER_BYTES;
      if (r == 1 && cur_max <= 300) return cur_max;
      if (r == 2) return $urandom_range(HEADER_BYTES, int'(roomy));
      return $urandom_range(HEADER_BYTES, int'(top));
   endfunction

   task automatic send_messages(input int target);
      int sent;
      longint unsigned len;
      sent = 0;
      while (sent < target) begin
         len = pick_msg_len();
         send_message(len);
         sent += int'(len);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_max(input longint unsigned v);
      drain();
      csr_valid           <= 1'b1;
      csr_max_message_len <= MAX_LEN_W'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_max(MAX_LEN_W'(v));
      cur_max = v & 64'h7FFF_FFFF;
   endtask

   task automatic run_receiver();
      int       gap;
      int       taken;
      beat_type got;
      taken = 0;
      forever begin
         gap = draw_gap(recv_run, recv_quiet);
         // long hold-off so the output register fills and the input stalls
         if (taken == 150 || taken == 480) gap = 90;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = '{data: rsp_out_byte, sof: rsp_first_of_message, eof: rsp_last_of_message,
                 status: frame_status_type'(rsp_frame_status)};
         sb.check_beat(got);
         taken++;
      end
   endtask

   initial begin
      logic [7:0]       opening_bytes [24];
      logic [LEN_W-1:0] bad_len;
      int               mode;

      opening_bytes = '{8'h04, 8'h00, 8'h00, 8'h00,
                        8'h05, 8'h00, 8'h00, 8'h00, 8'hFF,
                        8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                        8'h09, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h7E, 8'hAA, 8'h55};
      sb         = new();
      cur_max    = MAX_LEN_RESET;
      send_run   = 0;
      send_quiet = 1'b0;
      recv_run   = 0;
      recv_quiet = 1'b0;

      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_in_byte         <= 8'h00;
      rsp_ready           <= 1'b0;
      csr_valid           <= 1'b0;
      csr_max_message_len <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fork
         run_receiver();
      join_none

      // reset limit: header-only and short messages
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
      send_messages(60);

      // smallest legal limit: header-only messages only
      write_max(HEADER_BYTES);
      repeat (10) send_message(HEADER_BYTES);

      write_max(64'h7FFF_FFFF);
      send_messages(200);

      write_max($urandom_range(5, 200));
      send_messages(180);

      write_max(MAX_LEN_RESET);
      send_messages(150);

      // one sticky error per run: short length, oversized length or limit below header size
      mode = $urandom_range(0, 2);
      case (mode)
         0: begin
            bad_len = LEN_W'($urandom_range(0, HEADER_BYTES - 1));
         end
         1: begin
            write_max($urandom_range(4, 100000));
            bad_len = LEN_W'($urandom);
            if (bad_len <= LEN_W'(cur_max)) bad_len[LEN_W-1] = 1'b1;
         end
         default: begin
            write_max($urandom_range(0, HEADER_BYTES - 1));
            bad_len = LEN_W'($urandom_range(HEADER_BYTES, 20));
         end
      endcase
      send_header(bad_len);
      repeat (40) send_byte(8'($urandom));
      write_max($urandom_range(4, 1000));
      repeat (20) send_byte(8'($urandom));

      drain();
      repeat (5) @(posedge clock);
      if (sb.failures == 0) begin
         $display("length_prefixed_deframer regression: pass");
      end else begin
         $display("length_prefixed_deframer regression: fail");
      end
      $finish;
   end

endmodule
